// ===== src/bmsi_pkg.sv =====
// Package for the bank mapper with scanline interrupt counter.
// Holds the command codes, register indexes, reset tables and structs shared by the modules.
// No dependencies.
package bmsi_pkg;

  // Command carried by each input word.
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_PPU    = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  // Counter flavors selected by the variant register.
  localparam logic [1:0] VARIANT_FILTER3 = 2'd0;
  localparam logic [1:0] VARIANT_EDGE    = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_VARIANT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRG_AND  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRG_OR   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHR_AND  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHR_OR   = 3'd4;

  localparam int BANK_W = 10;

  // Reset contents of the eight bank registers.
  localparam logic [7:0] BANK_RESET [8] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};

  localparam logic [2:0] FILTER_SHORT   = 3'd3;
  localparam logic [2:0] FILTER_LONG    = 3'd5;
  localparam logic [2:0] PRESCALE_RESET = 3'd7;
  localparam logic [7:0] CHR_EVEN_MASK  = 8'hFE;
  localparam logic [6:0] PRG_FIXED_HI   = 7'h7F;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank_number;
    logic              irq_active;
    logic              mirror_horizontal;
    logic              wram_enable;
    logic              wram_write_protect;
  } result_t;

  typedef struct packed {
    logic [1:0]        counter_variant;
    logic [7:0]        prg_and_mask;
    logic [BANK_W-1:0] prg_or_bits;
    logic [7:0]        chr_and_mask;
    logic [BANK_W-1:0] chr_or_bits;
  } cfg_t;

  // Interrupt status reported by the core for checking.
  typedef struct packed {
    logic       irq_enable;
    logic       irq_line;
    logic [2:0] a12_filter;
  } status_t;

endpackage

// ===== src/bmsi_in_if.sv =====
// Input channel interface: valid/ready handshake with the command word.
// Depends on bmsi_pkg for nothing but field widths kept literal here.
interface bmsi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, cmd, address, data, input ready);
  modport sink   (input valid, cmd, address, data, output ready);
endinterface

// ===== src/bmsi_out_if.sv =====
// Result channel interface: valid/ready handshake with the result word.
// Field widths follow the result fields of the mapper.
interface bmsi_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] bank_number;
  logic       irq_active;
  logic       mirror_horizontal;
  logic       wram_enable;
  logic       wram_write_protect;

  modport source (output valid, bank_number, irq_active, mirror_horizontal, wram_enable,
                  wram_write_protect, input ready);
  modport sink   (input valid, bank_number, irq_active, mirror_horizontal, wram_enable,
                  wram_write_protect, output ready);
endinterface

// ===== src/bmsi_cfg_if.sv =====
// Configuration write channel interface: valid/ready with register index and data.
// Widths come from bmsi_pkg.
interface bmsi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmsi_pkg::CFG_INDEX_W-1:0] index;
  logic [bmsi_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bmsi_cfg.sv =====
// Configuration register file of the mapper.
// Depends on bmsi_pkg and bmsi_cfg_if.
module bmsi_cfg (
  input  logic            clk,
  input  logic            rst,
  bmsi_cfg_if.sink        cfg,
  output bmsi_pkg::cfg_t  regs
);
  import bmsi_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes by index; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.counter_variant <= VARIANT_FILTER3;
      regs.prg_and_mask    <= 8'd63;
      regs.prg_or_bits     <= '0;
      regs.chr_and_mask    <= 8'd255;
      regs.chr_or_bits     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_VARIANT: regs.counter_variant <= cfg.data[1:0];
        REG_PRG_AND: regs.prg_and_mask    <= cfg.data[7:0];
        REG_PRG_OR:  regs.prg_or_bits     <= cfg.data[BANK_W-1:0];
        REG_CHR_AND: regs.chr_and_mask    <= cfg.data[7:0];
        REG_CHR_OR:  regs.chr_or_bits     <= cfg.data[BANK_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== src/bmsi_core.sv =====
// Mapper state and single-pass command logic: register writes, scanline counter, bank lookup.
// Depends on bmsi_pkg.
module bmsi_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  bmsi_pkg::item_t   item,
  input  bmsi_pkg::cfg_t    regs,
  output bmsi_pkg::result_t result,
  output bmsi_pkg::status_t status
);
  import bmsi_pkg::*;

  logic [7:0] bank_select, bank_select_next;
  logic [7:0] bank_regs [8];
  logic [7:0] bank_regs_next [8];
  logic [7:0] mirror_ctrl, mirror_ctrl_next;
  logic [7:0] wram_ctrl, wram_ctrl_next;
  logic [7:0] irq_count, irq_count_next;
  logic [7:0] reload_latch, reload_latch_next;
  logic       reload_pending, reload_pending_next;
  logic       irq_enable, irq_enable_next;
  logic       irq_line, irq_line_next;
  logic [2:0] a12_filter, a12_filter_next;
  logic [2:0] edge_prescaler, edge_prescaler_next;
  logic       prev_a12, prev_a12_next;

  // Counter clock outcome, computed once and applied where a clock happens.
  logic [7:0] clk_count;
  logic       clk_zero_fire;
  logic       clk_trans_fire;

  always_comb begin
    clk_count      = (irq_count == 8'd0 || reload_pending) ? reload_latch : irq_count - 8'd1;
    clk_zero_fire  = (clk_count == 8'd0) && irq_enable;
    clk_trans_fire = clk_zero_fire && (irq_count != 8'd0 || reload_pending);
  end

  // Next state for the item in the input register.
  always_comb begin
    logic fives;
    logic a12;
    fives = (regs.counter_variant != VARIANT_FILTER3);
    a12   = item.address[12];
    bank_select_next    = bank_select;
    bank_regs_next      = bank_regs;
    mirror_ctrl_next    = mirror_ctrl;
    wram_ctrl_next      = wram_ctrl;
    irq_count_next      = irq_count;
    reload_latch_next   = reload_latch;
    reload_pending_next = reload_pending;
    irq_enable_next     = irq_enable;
    irq_line_next       = irq_line;
    a12_filter_next     = a12_filter;
    edge_prescaler_next = edge_prescaler;
    prev_a12_next       = prev_a12;
    case (item.cmd)
      CMD_WRITE: begin
        if (item.address[15]) begin
          case (item.address[14:13])
            2'd0: begin
              if (item.address[0]) bank_regs_next[bank_select[2:0]] = item.data;
              else bank_select_next = item.data;
            end
            2'd1: begin
              if (item.address[0]) wram_ctrl_next = item.data;
              else mirror_ctrl_next = item.data;
            end
            2'd2: begin
              if (item.address[0]) begin
                irq_count_next      = 8'd0;
                edge_prescaler_next = PRESCALE_RESET;
                reload_pending_next = 1'b1;
              end else begin
                reload_latch_next = item.data;
              end
            end
            default: begin
              irq_enable_next = item.address[0];
              if (!item.address[0]) irq_line_next = 1'b0;
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (a12_filter != 3'd0) a12_filter_next = a12_filter - 3'd1;
      end
      CMD_PPU: begin
        if (regs.counter_variant == VARIANT_EDGE) begin
          // Falling A12 edge advances the divide-by-8 prescaler.
          if (prev_a12 && !a12) begin
            edge_prescaler_next = edge_prescaler + 3'd1;
            if (edge_prescaler == 3'd0) begin
              irq_count_next      = clk_count;
              reload_pending_next = 1'b0;
              if (clk_zero_fire) irq_line_next = 1'b1;
            end
          end
          prev_a12_next = a12;
        end else if (a12) begin
          // A filtered rising A12 edge steps the counter.
          if (a12_filter == 3'd0) begin
            irq_count_next      = clk_count;
            reload_pending_next = 1'b0;
            if (fives ? clk_trans_fire : clk_zero_fire) irq_line_next = 1'b1;
          end
          a12_filter_next = fives ? FILTER_LONG : FILTER_SHORT;
        end
      end
      default: ;
    endcase
  end

  // Bank lookup: one bank register read, indexed by the command's address slot; writes and ticks give bank zero.
  always_comb begin
    logic [2:0] chr_slot;
    logic [1:0] prg_slot;
    logic [2:0] rd_index;
    logic [7:0] rd_data;
    logic [7:0] raw;
    logic [7:0] mask;
    logic [BANK_W-1:0] orb;
    chr_slot = item.address[12:10] ^ {bank_select[7], 2'b00};
    prg_slot = item.address[14:13] ^ {(!item.address[13]) & bank_select[6], 1'b0};
    if (item.cmd == CMD_PPU) begin
      rd_index = chr_slot[2] ? chr_slot - 3'd2 : {2'b00, chr_slot[1]};
    end else begin
      rd_index = {2'b11, prg_slot[0]};
    end
    rd_data = bank_regs[rd_index];
    if (item.cmd == CMD_PPU) begin
      raw  = chr_slot[2] ? rd_data : ((rd_data & CHR_EVEN_MASK) | {7'd0, chr_slot[0]});
      mask = regs.chr_and_mask;
      orb  = regs.chr_or_bits;
    end else begin
      raw  = prg_slot[1] ? {PRG_FIXED_HI, prg_slot[0]} : rd_data;
      mask = regs.prg_and_mask;
      orb  = regs.prg_or_bits;
    end
    if (item.cmd == CMD_PPU || item.cmd == CMD_LOOKUP) begin
      result.bank_number = {2'b00, raw & mask} | orb;
    end else begin
      result.bank_number = '0;
    end
    result.irq_active         = irq_line_next;
    result.mirror_horizontal  = mirror_ctrl_next[0];
    result.wram_enable        = wram_ctrl_next[7];
    result.wram_write_protect = wram_ctrl_next[6];
  end

  // State registers, updated when the word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select    <= '0;
      bank_regs      <= BANK_RESET;
      mirror_ctrl    <= '0;
      wram_ctrl      <= '0;
      irq_count      <= '0;
      reload_latch   <= '0;
      reload_pending <= 1'b0;
      irq_enable     <= 1'b0;
      irq_line       <= 1'b0;
      a12_filter     <= '0;
      edge_prescaler <= PRESCALE_RESET;
      prev_a12       <= 1'b0;
    end else if (fire) begin
      bank_select    <= bank_select_next;
      bank_regs      <= bank_regs_next;
      mirror_ctrl    <= mirror_ctrl_next;
      wram_ctrl      <= wram_ctrl_next;
      irq_count      <= irq_count_next;
      reload_latch   <= reload_latch_next;
      reload_pending <= reload_pending_next;
      irq_enable     <= irq_enable_next;
      irq_line       <= irq_line_next;
      a12_filter     <= a12_filter_next;
      edge_prescaler <= edge_prescaler_next;
      prev_a12       <= prev_a12_next;
    end
  end

  assign status.irq_enable = irq_enable;
  assign status.irq_line   = irq_line;
  assign status.a12_filter = a12_filter;
endmodule

// ===== src/bank_mapper_with_scanline_irq.sv =====
// Top level of the bank mapper with scanline interrupt counter.
// Depends on bmsi_pkg, the three channel interfaces, bmsi_cfg and bmsi_core.
//
//   channel | role   | moves
//   --------+--------+--------------------------------------------
//   req     | sink   | command word: cmd, address, data
//   rsp     | source | result word: bank and status bits
//   cfg     | sink   | register write: index, data (always ready)
//
// Each word is held in the input register, then its result is written to the
// output register; one word per clock while the result channel is not stalled.
// The state update and bank lookup are one combinational pass over the mapper registers.
// Reset is synchronous; no clearing pass, the block is ready the cycle after reset.
// A stalled result holds the output register; one more word waits in the input
// register, and req.ready drops only when both are full.
module bank_mapper_with_scanline_irq (
  input  logic      clk,
  input  logic      rst,
  bmsi_in_if.sink   req,
  bmsi_out_if.source rsp,
  bmsi_cfg_if.sink  cfg
);
  import bmsi_pkg::*;

  cfg_t    regs;
  item_t   pipe_item;
  logic    pipe_valid;
  logic    move;
  result_t result;
  result_t out_word;
  status_t status;

  bmsi_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bmsi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (move),
    .item   (pipe_item),
    .regs   (regs),
    .result (result),
    .status (status)
  );

  // A word moves on when the output register is free or being emptied.
  assign move      = pipe_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !pipe_valid || move;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (req.ready) begin
      pipe_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      pipe_item.cmd     <= cmd_t'(req.cmd);
      pipe_item.address <= req.address;
      pipe_item.data    <= req.data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_word <= result;
  end

  assign rsp.bank_number        = out_word.bank_number;
  assign rsp.irq_active         = out_word.irq_active;
  assign rsp.mirror_horizontal  = out_word.mirror_horizontal;
  assign rsp.wram_enable        = out_word.wram_enable;
  assign rsp.wram_write_protect = out_word.wram_write_protect;

  // The interrupt line is only ever raised while enabled, and disable drops it.
  a_irq_needs_enable: assert property (@(posedge clk) disable iff (rst)
    status.irq_line |-> status.irq_enable)
    else $error("irq line high while irq disabled");

  // The A12 filter is only loaded with one of the two filter lengths, so it never exceeds the long one.
  a_filter_range: assert property (@(posedge clk) disable iff (rst)
    status.a12_filter <= FILTER_LONG)
    else $error("a12 filter out of range");

  // A waiting word is kept while the result stays stalled.
  a_word_kept: assert property (@(posedge clk) disable iff (rst)
    pipe_valid && rsp.valid && !rsp.ready |=> pipe_valid && $stable(pipe_item))
    else $error("input word lost during output stall");

  // Input is refused only when both registers hold a word.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> pipe_valid && rsp.valid)
    else $error("input refused with free space");
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bank_mapper_with_scanline_irq.
// Uses bmsi_pkg and the three channel interfaces. A local model of the mapper predicts
// every result word, and a monitor compares the words field by field as they arrive.
module tb_top;
  import bmsi_pkg::*;

  // Write decode groups, chosen by address bits 14:13.
  localparam logic [1:0] SEL_BANK   = 2'd0;
  localparam logic [1:0] SEL_MIRROR = 2'd1;
  localparam logic [1:0] SEL_RELOAD = 2'd2;
  localparam logic [1:0] SEL_IRQ    = 2'd3;

  // Counter flavors and a register index that the block does not decode.
  localparam logic [1:0] VARIANT_FILTER5 = 2'd1;
  localparam logic [1:0] VARIANT_ALIAS   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst;

  bmsi_in_if  req_ch ();
  bmsi_out_if rsp_ch ();
  bmsi_cfg_if cfg_ch ();

  bank_mapper_with_scanline_irq u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the mapper state and its configuration.
  cfg_t       cfg_m;
  logic [7:0] bank_sel;
  logic [7:0] bank_reg [8];
  logic [7:0] mirror_reg;
  logic [7:0] wram_reg;
  logic [7:0] irq_cnt;
  logic [7:0] irq_latch;
  logic       reload_pend;
  logic       irq_en;
  logic       irq_out;
  logic [2:0] a12_cnt;
  logic [2:0] prescale;
  logic       last_a12;

  item_t   cmd_words [$];
  result_t mapper_out_q [$];
  int      words_made = 0;
  int      errors = 0;

  item_t   drv_word;
  item_t   mon_word;
  result_t mon_got;
  result_t mon_want;
  logic    req_taken;
  int      send_gap = 0;
  int      send_calm = 0;
  int      rsp_stall = 0;
  int      rsp_calm = 0;

  // One clock of the scanline counter. With trans_only set, the line fires only when
  // the count falls from nonzero to zero or when a reload was requested.
  function automatic void count_clock(input logic trans_only);
    logic [7:0] was;
    was = irq_cnt;
    if (irq_cnt == 8'd0 || reload_pend) irq_cnt = irq_latch;
    else irq_cnt = irq_cnt - 8'd1;
    if (irq_cnt == 8'd0 && irq_en && (!trans_only || was != 8'd0 || reload_pend))
      irq_out = 1'b1;
    reload_pend = 1'b0;
  endfunction

  // Applies one command word to the local state and returns the result word it yields.
  function automatic result_t map_word(input item_t w);
    result_t    r;
    logic       a12;
    logic       long_filter;
    logic [2:0] p;
    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
    logic [7:0] b;
    r = '0;
    case (w.cmd)
      CMD_WRITE: begin
        if (w.address[15]) begin
          case (w.address[14:13])
            SEL_BANK: begin
              if (w.address[0]) bank_reg[bank_sel[2:0]] = w.data;
              else bank_sel = w.data;
            end
            SEL_MIRROR: begin
              if (w.address[0]) wram_reg = w.data;
              else mirror_reg = w.data;
            end
            SEL_RELOAD: begin
              if (w.address[0]) begin
                irq_cnt = 8'd0;
                prescale = PRESCALE_RESET;
                reload_pend = 1'b1;
              end else begin
                irq_latch = w.data;
              end
            end
            default: begin
              irq_en = w.address[0];
              if (!irq_en) irq_out = 1'b0;
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (a12_cnt != 3'd0) a12_cnt = a12_cnt - 3'd1;
      end
      CMD_PPU: begin
        a12 = w.address[12];
        if (cfg_m.counter_variant == VARIANT_EDGE) begin
          // Falling edges of A12 go through a divide-by-8 prescaler.
          if (last_a12 && !a12) begin
            p = prescale;
            prescale = p + 3'd1;
            if (p == 3'd0) count_clock(1'b0);
          end
          last_a12 = a12;
        end else if (a12) begin
          long_filter = cfg_m.counter_variant != VARIANT_FILTER3;
          if (a12_cnt == 3'd0) count_clock(long_filter);
          a12_cnt = long_filter ? FILTER_LONG : FILTER_SHORT;
        end
        // CHR slot from bits 12:10, with the upper and lower halves swapped by bit 7.
        chr_slot = w.address[12:10];
        if (bank_sel[7]) chr_slot[2] = ~chr_slot[2];
        if (chr_slot[2]) b = bank_reg[chr_slot - 3'd2];
        else b = (bank_reg[{2'b00, chr_slot[1]}] & CHR_EVEN_MASK) | {7'd0, chr_slot[0]};
        r.bank_number = {2'b00, b & cfg_m.chr_and_mask} | cfg_m.chr_or_bits;
      end
      default: begin
        // PRG slot from bits 14:13; bit 6 swaps the first and third slots.
        prg_slot = w.address[14:13];
        if (!prg_slot[0] && bank_sel[6]) prg_slot[1] = ~prg_slot[1];
        b = prg_slot[1] ? {PRG_FIXED_HI, prg_slot[0]} : bank_reg[{2'b11, prg_slot[0]}];
        r.bank_number = {2'b00, b & cfg_m.prg_and_mask} | cfg_m.prg_or_bits;
      end
    endcase
    r.irq_active         = irq_out;
    r.mirror_horizontal  = mirror_reg[0];
    r.wram_enable        = wram_reg[7];
    r.wram_write_protect = wram_reg[6];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Sender: presents the next command word at the falling edge once the last one is taken, with random gaps.
  always @(negedge clk) begin
    if (!rst && (!req_ch.valid || req_taken)) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_words.size() > 0) begin
        drv_word = cmd_words.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= drv_word.cmd;
        req_ch.address <= drv_word.address;
        req_ch.data    <= drv_word.data;
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap <= 0;
        end else begin
          send_gap <= pick_gap();
          if ($urandom_range(0, 31) == 0) send_calm <= $urandom_range(20, 80);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure on the result channel.
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_stall <= rsp_stall - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rsp_calm > 0) begin
          rsp_calm <= rsp_calm - 1;
        end else begin
          rsp_stall <= pick_gap();
          if ($urandom_range(0, 31) == 0) rsp_calm <= $urandom_range(20, 80);
        end
      end
    end
  end

  // Monitor: checks each result word, then predicts the result of a newly taken word.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        mon_got.bank_number        = rsp_ch.bank_number;
        mon_got.irq_active         = rsp_ch.irq_active;
        mon_got.mirror_horizontal  = rsp_ch.mirror_horizontal;
        mon_got.wram_enable        = rsp_ch.wram_enable;
        mon_got.wram_write_protect = rsp_ch.wram_write_protect;
        if (mapper_out_q.size() == 0) begin
          note_mismatch("unrequested result, bank_number", 0, mon_got.bank_number);
        end else begin
          mon_want = mapper_out_q.pop_front();
          if (mon_got.bank_number !== mon_want.bank_number)
            note_mismatch("bank_number", mon_want.bank_number, mon_got.bank_number);
          if (mon_got.irq_active !== mon_want.irq_active)
            note_mismatch("irq_active", mon_want.irq_active, mon_got.irq_active);
          if (mon_got.mirror_horizontal !== mon_want.mirror_horizontal)
            note_mismatch("mirror_horizontal", mon_want.mirror_horizontal,
                          mon_got.mirror_horizontal);
          if (mon_got.wram_enable !== mon_want.wram_enable)
            note_mismatch("wram_enable", mon_want.wram_enable, mon_got.wram_enable);
          if (mon_got.wram_write_protect !== mon_want.wram_write_protect)
            note_mismatch("wram_write_protect", mon_want.wram_write_protect,
                          mon_got.wram_write_protect);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        mon_word.cmd     = cmd_t'(req_ch.cmd);
        mon_word.address = req_ch.address;
        mon_word.data    = req_ch.data;
        mapper_out_q.push_back(map_word(mon_word));
      end
    end
  end

  task automatic queue_word(input cmd_t c, input logic [15:0] a, input logic [7:0] d);
    item_t w;
    w.cmd = c;
    w.address = a;
    w.data = d;
    cmd_words.push_back(w);
    words_made++;
  endtask

  // Register write at 0x8000 and above; the bits between the group and A0 are random.
  task automatic queue_write(input logic [1:0] sel, input logic a0, input logic [7:0] d);
    logic [11:0] mid;
    mid = 12'($urandom);
    queue_word(CMD_WRITE, {1'b1, sel, mid, a0}, d);
  endtask

  function automatic logic [15:0] ppu_addr(input logic a12);
    logic [15:0] a;
    a = 16'($urandom);
    a[12] = a12;
    return a;
  endfunction

  // Random traffic: mostly scanline fetch patterns and counter setup, plus bank and mirror writes and noise.
  task automatic queue_random(input int n);
    int stop_at;
    int pick;
    stop_at = words_made + n;
    while (words_made < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_word(cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end else if (pick < 35) begin
        if ($urandom_range(0, 3) == 0) queue_write(SEL_RELOAD, 1'b0, 8'($urandom));
        else queue_write(SEL_RELOAD, 1'b0, 8'($urandom_range(0, 6)));
        if ($urandom_range(0, 3) != 0) queue_write(SEL_RELOAD, 1'b1, 8'($urandom));
        queue_write(SEL_IRQ, $urandom_range(0, 4) != 0, 8'($urandom));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) begin
          repeat ($urandom_range(1, 4)) queue_word(CMD_PPU, ppu_addr(1'b0), 8'($urandom));
          repeat ($urandom_range(1, 3)) queue_word(CMD_PPU, ppu_addr(1'b1), 8'($urandom));
          repeat ($urandom_range(0, 6)) queue_word(CMD_TICK, 16'($urandom), 8'($urandom));
        end
      end else if (pick < 90) begin
        queue_write(SEL_BANK, 1'b0, 8'($urandom));
        queue_write(SEL_BANK, 1'b1, 8'($urandom));
        queue_word(CMD_LOOKUP, 16'($urandom), 8'($urandom));
        queue_word(CMD_PPU, 16'($urandom), 8'($urandom));
      end else begin
        queue_write(SEL_MIRROR, 1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  // Waits until every word has been sent and every result has come back.
  task automatic drain();
    do @(posedge clk);
    while (cmd_words.size() != 0 || req_ch.valid || mapper_out_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves valid high on return so back-to-back writes never drop it within a step.
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    case (idx)
      REG_VARIANT: cfg_m.counter_variant = val[1:0];
      REG_PRG_AND: cfg_m.prg_and_mask = val[7:0];
      REG_PRG_OR:  cfg_m.prg_or_bits = val;
      REG_CHR_AND: cfg_m.chr_and_mask = val[7:0];
      REG_CHR_OR:  cfg_m.chr_or_bits = val;
      default: ;
    endcase
  endtask

  // One setting of all registers while idle, then a stretch of random words.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] variant, input logic [CFG_DATA_W-1:0] pa,
                           input logic [CFG_DATA_W-1:0] po, input logic [CFG_DATA_W-1:0] ca,
                           input logic [CFG_DATA_W-1:0] co, input int n);
    drain();
    set_reg(REG_VARIANT, variant);
    set_reg(REG_PRG_AND, pa);
    set_reg(REG_PRG_OR, po);
    set_reg(REG_CHR_AND, ca);
    set_reg(REG_CHR_OR, co);
    set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    queue_random(n);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.cmd     = '0;
    req_ch.address = '0;
    req_ch.data    = '0;
    rsp_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;

    // Model state after reset.
    cfg_m = '{counter_variant: 2'd0, prg_and_mask: 8'd63, prg_or_bits: '0,
              chr_and_mask: 8'd255, chr_or_bits: '0};
    bank_sel = '0;
    for (int i = 0; i < 8; i++) bank_reg[i] = BANK_RESET[i];
    mirror_reg  = '0;
    wram_reg    = '0;
    irq_cnt     = '0;
    irq_latch   = '0;
    reload_pend = 1'b0;
    irq_en      = 1'b0;
    irq_out     = 1'b0;
    a12_cnt     = '0;
    prescale    = PRESCALE_RESET;
    last_a12    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset configuration: lookups in every slot, with and
    // without address bit 15, PPU fetches below and above 0x2000, ignored low writes,
    // every register group, and an interrupt that fires and is then dropped.
    queue_word(CMD_LOOKUP, 16'h0000, 8'h00);
    queue_word(CMD_LOOKUP, 16'hA000, 8'hFF);
    queue_word(CMD_LOOKUP, 16'hC000, 8'h00);
    queue_word(CMD_LOOKUP, 16'hFFFF, 8'hFF);
    queue_word(CMD_PPU, 16'h0000, 8'h00);
    queue_word(CMD_PPU, 16'h1C00, 8'h00);
    queue_word(CMD_PPU, 16'h2C00, 8'h00);
    queue_word(CMD_PPU, 16'hFFFF, 8'hFF);
    repeat (3) queue_word(CMD_TICK, 16'hFFFF, 8'hFF);
    queue_word(CMD_WRITE, 16'h7FFF, 8'hFF);
    queue_word(CMD_WRITE, 16'h8000, 8'hC7);
    queue_word(CMD_WRITE, 16'h8001, 8'hFF);
    queue_word(CMD_WRITE, 16'hA000, 8'h01);
    queue_word(CMD_WRITE, 16'hA001, 8'hC0);
    queue_word(CMD_WRITE, 16'hC000, 8'h01);
    queue_word(CMD_WRITE, 16'hC001, 8'h00);
    queue_word(CMD_WRITE, 16'hE001, 8'h00);
    queue_word(CMD_PPU, 16'h1000, 8'h00);
    repeat (3) queue_word(CMD_TICK, 16'h0000, 8'h00);
    queue_word(CMD_PPU, 16'h1000, 8'h00);
    queue_word(CMD_LOOKUP, 16'h8000, 8'h00);
    queue_word(CMD_PPU, 16'h0400, 8'h00);
    queue_word(CMD_WRITE, 16'hE000, 8'h00);

    // Settings with the widest and narrowest masks, random masks, and every counter flavor.
    run_phase(CFG_DATA_W'(VARIANT_FILTER3), 10'h0FF, 10'h000, 10'h0FF, 10'h000, 280);
    run_phase(CFG_DATA_W'(VARIANT_FILTER5), 10'h000, 10'h3FF, 10'h000, 10'h3FF, 280);
    run_phase(CFG_DATA_W'(VARIANT_EDGE), 10'($urandom_range(0, 255)),
              10'($urandom_range(0, 1023)), 10'($urandom_range(0, 255)),
              10'($urandom_range(0, 1023)), 280);
    run_phase(CFG_DATA_W'(VARIANT_ALIAS), 10'h0FF, 10'($urandom_range(0, 15)), 10'h0FF,
              10'($urandom_range(0, 15)), 280);
    // Upper data bits beyond each register's width are written random.
    run_phase({8'($urandom), 2'($urandom_range(0, 2))}, 10'($urandom), 10'($urandom),
              10'($urandom), 10'($urandom), 280);

    drain();
    repeat (8) @(posedge clk);
    if (mapper_out_q.size() != 0)
      $display("%0d result words never arrived", mapper_out_q.size());
    if (errors == 0 && mapper_out_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/bmsi_pkg.sv
src/bmsi_in_if.sv
src/bmsi_out_if.sv
src/bmsi_cfg_if.sv
src/bmsi_cfg.sv
src/bmsi_core.sv
src/bank_mapper_with_scanline_irq.sv
test/tb_top.sv
